// ===== hdl/dsc_pkg.sv =====
// Shared types and constants of the distinct subsequence counter.
// No dependencies; used by dsc_ctrl, dsc_datapath and the top level.
`default_nettype none
package dsc_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int CHAR_W          = 8;
  localparam int IDX_W           = 4;
  localparam int LEN_W           = 5;
  localparam int COUNT_W         = 32;
  localparam int IN_DATA_W       = 16;
  localparam int CFG_DATA_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } ctrl_state_t;

  typedef struct packed {
    logic load_pat;
    logic step_text;
    logic out_load;
  } dsc_cmd_t;

  typedef struct packed {
    logic text_item;
  } dsc_sts_t;

endpackage
`default_nettype wire

// ===== hdl/dsc_ctrl.sv =====
// Controller of the distinct subsequence counter: handshakes and output slot.
// Depends on dsc_pkg.
`default_nettype none
module dsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire dsc_pkg::dsc_sts_t sts,
  output dsc_pkg::dsc_cmd_t      cmd
);

  dsc_pkg::ctrl_state_t state_r, state_nxt;
  logic accept;

  assign in_tready  = rst_n && ((state_r == dsc_pkg::ST_EMPTY) || out_tready);
  assign out_tvalid = (state_r == dsc_pkg::ST_FULL);
  assign accept     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsc_pkg::ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsc_pkg::ST_EMPTY: begin
        if (accept && sts.text_item) state_nxt = dsc_pkg::ST_FULL;
      end
      dsc_pkg::ST_FULL: begin
        if (out_tready) begin
          state_nxt = (accept && sts.text_item) ? dsc_pkg::ST_FULL : dsc_pkg::ST_EMPTY;
        end
      end
      default: state_nxt = dsc_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    cmd.load_pat  = accept && !sts.text_item;
    cmd.step_text = accept && sts.text_item;
    cmd.out_load  = accept && sts.text_item;
  end

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_text |=> out_tvalid)
    else $error("text beat did not produce a result");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result slot is blocked");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !cmd.step_text) |=> !out_tvalid)
    else $error("result repeated after it was taken");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_pat |-> !cmd.out_load)
    else $error("load beat produced a result");

endmodule
`default_nettype wire

// ===== hdl/dsc_datapath.sv =====
// Datapath of the distinct subsequence counter: pattern store, prefix counts,
// saturating adders and the result register. Depends on dsc_pkg.
`default_nettype none
module dsc_datapath #(
  parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dsc_pkg::dsc_cmd_t                cmd,
  output dsc_pkg::dsc_sts_t                     sts,
  input  wire logic                             in_func,
  input  wire logic [dsc_pkg::CHAR_W-1:0]       in_char,
  input  wire logic [dsc_pkg::IDX_W-1:0]        in_idx,
  input  wire logic                             in_last,
  input  wire logic                             cfg_we,
  input  wire logic [dsc_pkg::LEN_W-1:0]        cfg_len,
  output logic [dsc_pkg::COUNT_W-1:0]           out_count,
  output logic                                  out_saturated,
  output logic                                  out_final
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = dsc_pkg::COUNT_W;

  logic [dsc_pkg::CHAR_W-1:0] pat_r    [MAX_PATTERN];
  logic [CW-1:0]              counts_r [MAX_PATTERN];
  logic [CW-1:0]              upd      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     sat;
  logic                       flag_r, flag_nxt;
  logic [dsc_pkg::LEN_W-1:0]  len_r;
  logic [LW-1:0]              eff_len;
  logic [IW-1:0]              sel;
  logic [CW-1:0]              result;
  logic [CW-1:0]              out_count_r;
  logic                       out_sat_r, out_final_r;

  assign sts.text_item = (in_func == dsc_pkg::FUNC_TEXT);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
    logic [CW:0] shorter, sum;
    logic        hit;
    if (k == 0) begin : g_first
      assign shorter = (CW+1)'(1);
    end else begin : g_rest
      assign shorter = {1'b0, counts_r[k-1]};
    end
    assign sum    = {1'b0, counts_r[k]} + shorter;
    assign hit    = (32'(len_r) > 32'(k)) && (pat_r[k] == in_char);
    assign sat[k] = hit && (sum >= {1'b0, dsc_pkg::COUNT_MAX});
    assign upd[k] = !hit ? counts_r[k] : (sat[k] ? dsc_pkg::COUNT_MAX : sum[CW-1:0]);
  end

  assign flag_nxt = flag_r | (|sat);

  always_comb begin
    if (32'(len_r) >= 32'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(len_r);
    end
    sel    = IW'(eff_len - LW'(1));
    result = (eff_len == '0) ? CW'(1) : upd[sel];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pat && (32'(in_idx) < 32'(MAX_PATTERN))) begin
      pat_r[IW'(in_idx)] <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) counts_r[i] <= '0;
      flag_r <= 1'b0;
    end else if (cmd.step_text) begin
      for (int i = 0; i < MAX_PATTERN; i++) counts_r[i] <= in_last ? '0 : upd[i];
      flag_r <= in_last ? 1'b0 : flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= result;
      out_sat_r   <= flag_nxt;
      out_final_r <= in_last;
    end
  end

  assign out_count     = out_count_r;
  assign out_saturated = out_sat_r;
  assign out_final     = out_final_r;

endmodule
`default_nettype wire

// ===== hdl/distinct_subsequence_counter.sv =====
// Distinct subsequence counter, top level. Depends on dsc_pkg, dsc_ctrl, dsc_datapath.
// An accepted text beat gives its result beat in the next cycle; load beats give none.
// Throughput: one beat per cycle; all pattern positions update in parallel adders. A waiting
// result holds the input; the next beat enters in the cycle its result is taken.
// Reset: synchronous, active low; clears prefix counts, saturation flag and pattern
// length, and no beat is taken while it is held. The pattern store is not cleared.
`default_nettype none
module distinct_subsequence_counter #(
  parameter int MAX_PATTERN = dsc_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [dsc_pkg::IN_DATA_W-1:0]       in_tdata,  // char_value, pattern_index, pad
  input  wire logic                                in_tuser,  // func
  input  wire logic                                in_tlast,  // is_last
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [dsc_pkg::COUNT_W-1:0]              out_tdata, // count
  output logic                                     out_tuser, // saturated
  output logic                                     out_tlast, // final_result
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dsc_pkg::CFG_DATA_W-1:0]      cfg_data   // pattern_length, pad
);

  dsc_pkg::dsc_cmd_t cmd;
  dsc_pkg::dsc_sts_t sts;

  assign cfg_ready = rst_n;

  dsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dsc_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_tuser),
    .in_char       (in_tdata[dsc_pkg::CHAR_W-1:0]),
    .in_idx        (in_tdata[dsc_pkg::CHAR_W +: dsc_pkg::IDX_W]),
    .in_last       (in_tlast),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_len       (cfg_data[dsc_pkg::LEN_W-1:0]),
    .out_count     (out_tdata),
    .out_saturated (out_tuser),
    .out_final     (out_tlast)
  );

endmodule
`default_nettype wire
